// ===== sv/slbc_pkg.sv =====
package slbc_pkg;

	// Row size default and item widths
	localparam int LED_COUNT_DEF = 4;
	localparam int BTN_W         = 3;
	localparam int PERIOD_W      = 10;
	localparam int MODE_W        = 2;
	localparam int LEDS_OUT_W    = 4;
	localparam int TIME_W        = 32;
	localparam int DEB_W         = 8;
	localparam int IN_DATA_W     = 8;
	localparam int OUT_DATA_W    = 24;
	localparam int STEP_W        = 9;
	localparam int STEP_MAX      = 511;

	// Period limits and reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;
	localparam logic [PERIOD_W-1:0] PERIOD_INC   = 10'd100;
	localparam logic [PERIOD_W-1:0] PERIOD_LO    = 10'd200;
	localparam logic [PERIOD_W-1:0] PERIOD_HI    = 10'd800;
	localparam logic [DEB_W-1:0]    DEBOUNCE_RESET = 8'd50;

	// Reciprocal of ten: (x * 205) >> 11 is exact for every 10-bit x
	localparam logic [7:0] RECIP10_MUL   = 8'd205;
	localparam int         RECIP10_SHIFT = 11;

	// Blink modes
	localparam logic [MODE_W-1:0] MODE_FINE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MID    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_COARSE = 2'd3;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_PRESS = 1'b1
	} op_t;

	typedef enum logic [BTN_W-1:0] {
		BTN_NEXT   = 3'd0,
		BTN_TOGGLE = 3'd1,
		BTN_PREV   = 3'd2,
		BTN_DOWN   = 3'd3,
		BTN_UP     = 3'd4
	} btn_t;

	// Datapath operations selected by the control word
	typedef enum logic [2:0] {
		D_NOP,
		D_LOAD,
		D_DIV,
		D_LED,
		D_TIME_INC,
		D_PRESS,
		D_EMIT
	} dp_op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_PRESS,
		C_DIV_MORE,
		C_LED_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef logic [2:0] pc_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		pc_t    tgt;
	} ctrl_word_t;

	// Program addresses
	localparam pc_t PC_PRESS    = 3'd0;
	localparam pc_t PC_EMIT     = 3'd1;
	localparam pc_t PC_IDLE     = 3'd2;
	localparam pc_t PC_DISPATCH = 3'd3;
	localparam pc_t PC_DIV      = 3'd4;
	localparam pc_t PC_LED      = 3'd5;
	localparam pc_t PC_TICK_END = 3'd6;

	// Control store: taken jump goes to tgt, otherwise fall through to pc + 1
	function automatic ctrl_word_t ucode_rom(input pc_t pc);
		ctrl_word_t w;
		unique case (pc)
			PC_PRESS:    w = '{op: D_PRESS,    cond: C_NEVER,    tgt: PC_EMIT};
			PC_EMIT:     w = '{op: D_EMIT,     cond: C_OUT_BUSY, tgt: PC_EMIT};
			PC_IDLE:     w = '{op: D_LOAD,     cond: C_NO_ITEM,  tgt: PC_IDLE};
			PC_DISPATCH: w = '{op: D_NOP,      cond: C_PRESS,    tgt: PC_PRESS};
			PC_DIV:      w = '{op: D_DIV,      cond: C_DIV_MORE, tgt: PC_DIV};
			PC_LED:      w = '{op: D_LED,      cond: C_LED_MORE, tgt: PC_LED};
			PC_TICK_END: w = '{op: D_TIME_INC, cond: C_ALWAYS,   tgt: PC_EMIT};
			default:     w = '{op: D_NOP,      cond: C_ALWAYS,   tgt: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/staggered_led_blink_controller_unit.sv =====
// Sequence: a beat is taken in IDLE and dispatched; a press is applied in PRESS, then
// EMIT; a tick runs 32 remainder steps and one step per LED, then TICK_END and EMIT.
// A new beat is taken only after the last item is emitted; EMIT waits while the output
// is stalled, and the one-bit-per-cycle remainder unit and the per-LED step set the pace.
// Reset (arst_n low, asynchronous): time and last press 0, mode 1, period 100,
// disabled, LEDs dark, debounce 50, no result pending.
module staggered_led_blink_controller_unit #(
	parameter int LED_COUNT = slbc_pkg::LED_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slbc_pkg::DEB_W-1:0]          cfg_wdata,     // debounce_ms
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [slbc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [2:0] button
	input  logic [0:0]                          s_axis_tuser,  // [0] operation
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [3:0] led_levels, [5:4] stagger mode, [15:6] period_ms, [16] enabled
	output logic [slbc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import slbc_pkg::*;

	localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int DW = $clog2(STEP_MAX * LED_COUNT + 1);
	localparam logic [IW-1:0] LED_LAST = IW'(LED_COUNT - 1);

	// Sequencer
	pc_t        pc_q, pc_d;
	ctrl_word_t ctrl;
	logic       jump;

	// Architectural state
	logic [DEB_W-1:0]     debounce_q;
	logic [TIME_W-1:0]    now_q;
	logic [TIME_W-1:0]    last_press_q;
	logic [MODE_W-1:0]    mode_q;
	logic [PERIOD_W-1:0]  period_q;
	logic                 enable_q;
	logic [LED_COUNT-1:0] led_q;

	// Working registers
	op_t                  op_q;
	logic [BTN_W-1:0]     btn_q;
	logic [STEP_W-1:0]    step_q;
	logic [TIME_W-1:0]    div_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [4:0]           bit_cnt_q;
	logic [IW-1:0]        led_idx_q;
	logic [DW-1:0]        dacc_q;
	logic [PERIOD_W-1:0]  dmod_q;

	// Output register
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic in_fire, out_free;

	// Datapath combinational terms
	logic [17:0]           tenth_prod;
	logic [STEP_W-1:0]     step_d;
	logic [PERIOD_W:0]     div_trial;
	logic [PERIOD_W-1:0]   rem_d;
	logic [DW-1:0]         delay_full;
	logic [PERIOD_W:0]     dmod_raw;
	logic [PERIOD_W-1:0]   dmod_d;
	logic [PERIOD_W:0]     phase_diff;
	logic [PERIOD_W-1:0]   phase;
	logic                  reached;
	logic                  led_bit_d;
	logic [TIME_W-1:0]     elapsed;
	logic                  press_ok;
	logic [LEDS_OUT_W-1:0] leds_out;

	assign ctrl          = ucode_rom(pc_q);
	assign s_axis_tready = (ctrl.op == D_LOAD);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Evaluate the jump condition of the current control word
	always_comb begin
		case (ctrl.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_ITEM:  jump = !s_axis_tvalid;
			C_PRESS:    jump = (op_q == OP_PRESS);
			C_DIV_MORE: jump = (bit_cnt_q != 5'd0);
			C_LED_MORE: jump = (led_idx_q != LED_LAST);
			C_OUT_BUSY: jump = !out_free;
			default:    jump = 1'b0;
		endcase
		pc_d = jump ? ctrl.tgt : pc_t'(pc_q + 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Stagger step: half, quarter or tenth of the period
	always_comb begin
		tenth_prod = period_q * RECIP10_MUL;
		case (mode_q)
			MODE_COARSE: step_d = STEP_W'(period_q >> 1);
			MODE_MID:    step_d = STEP_W'(period_q >> 2);
			default:     step_d = STEP_W'(tenth_prod >> RECIP10_SHIFT);
		endcase
	end

	// One restoring remainder step of now_ms by the period
	always_comb begin
		div_trial = {rem_q, div_q[TIME_W-1]};
		if (div_trial >= {1'b0, period_q}) begin
			rem_d = PERIOD_W'(div_trial - {1'b0, period_q});
		end else begin
			rem_d = div_trial[PERIOD_W-1:0];
		end
	end

	// Per-LED phase: (t - delay) mod period from t mod period and delay mod period
	always_comb begin
		delay_full = dacc_q + DW'(step_q);
		dmod_raw   = {1'b0, dmod_q} + (PERIOD_W+1)'(step_q);
		if (dmod_raw >= {1'b0, period_q}) begin
			dmod_d = PERIOD_W'(dmod_raw - {1'b0, period_q});
		end else begin
			dmod_d = dmod_raw[PERIOD_W-1:0];
		end
		phase_diff = {1'b0, rem_q} - {1'b0, dmod_d};
		if (phase_diff[PERIOD_W]) begin
			phase = phase_diff[PERIOD_W-1:0] + period_q;
		end else begin
			phase = phase_diff[PERIOD_W-1:0];
		end
		reached   = (now_q >= TIME_W'(delay_full));
		led_bit_d = led_q[led_idx_q];
		if (reached) begin
			if (!enable_q) begin
				led_bit_d = 1'b0;
			end else if (phase == '0) begin
				led_bit_d = 1'b1;
			end
			if (phase == (period_q >> 1)) begin
				led_bit_d = 1'b0;
			end
		end
	end

	// Debounce window check
	assign elapsed  = now_q - last_press_q;
	assign press_ok = (btn_q <= BTN_UP) && (elapsed > TIME_W'(debounce_q));

	// Visible LED bits, zero above the row
	always_comb begin
		for (int i = 0; i < LEDS_OUT_W; i++) begin
			leds_out[i] = (i < LED_COUNT) ? led_q[i % LED_COUNT] : 1'b0;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	// Architectural state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			last_press_q <= '0;
			mode_q       <= MODE_FINE;
			period_q     <= PERIOD_RESET;
			enable_q     <= 1'b0;
			led_q        <= '0;
		end else begin
			case (ctrl.op)
				D_LED: begin
					led_q[led_idx_q] <= led_bit_d;
				end
				D_TIME_INC: begin
					now_q <= now_q + TIME_W'(1);
				end
				D_PRESS: begin
					if (press_ok) begin
						last_press_q <= now_q;
						case (btn_q)
							BTN_NEXT: begin
								mode_q <= (mode_q >= MODE_COARSE) ? MODE_FINE
									: MODE_W'(mode_q + 2'd1);
							end
							BTN_TOGGLE: begin
								enable_q <= !enable_q;
							end
							BTN_PREV: begin
								mode_q <= (mode_q > MODE_FINE) ? MODE_W'(mode_q - 2'd1)
									: MODE_COARSE;
							end
							BTN_DOWN: begin
								if (period_q >= PERIOD_LO) begin
									period_q <= period_q - PERIOD_INC;
								end
							end
							BTN_UP: begin
								if (period_q < PERIOD_HI) begin
									period_q <= period_q + PERIOD_INC;
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers: capture the beat, run the remainder and the LED walk
	always_ff @(posedge clk) begin
		case (ctrl.op)
			D_LOAD: begin
				if (in_fire) begin
					op_q  <= op_t'(s_axis_tuser[0]);
					btn_q <= s_axis_tdata[BTN_W-1:0];
				end
				step_q    <= step_d;
				div_q     <= now_q;
				rem_q     <= '0;
				bit_cnt_q <= 5'd31;
				led_idx_q <= '0;
				dacc_q    <= '0;
				dmod_q    <= '0;
			end
			D_DIV: begin
				rem_q     <= rem_d;
				div_q     <= {div_q[TIME_W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - 5'd1;
			end
			D_LED: begin
				dacc_q    <= delay_full;
				dmod_q    <= dmod_d;
				led_idx_q <= led_idx_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

	// Output register: load on emit, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl.op == D_EMIT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == D_EMIT && out_free) begin
			m_data_q <= {7'd0, enable_q, period_q, mode_q, leds_out};
		end
	end

endmodule

// ===== sv/slbc_checker.sv =====
module slbc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [slbc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import slbc_pkg::*;

	logic [PERIOD_W:0] prev_period_q;
	logic [PERIOD_W:0] out_period;

	assign out_period = {1'b0, m_axis_tdata[15:6]};

	// Track the period of the last delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_period_q <= {1'b0, PERIOD_RESET};
		end else if (m_axis_tvalid && m_axis_tready) begin
			prev_period_q <= out_period;
		end
	end

	// Hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// One item in work at a time: no back-to-back input beats
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while previous item in work");

	// Period moves by one increment at most between delivered beats
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |->
			(out_period == prev_period_q) ||
			(out_period == prev_period_q + {1'b0, PERIOD_INC}) ||
			(prev_period_q == out_period + {1'b0, PERIOD_INC}))
		else $error("period jumped by more than one increment");

endmodule

bind staggered_led_blink_controller_unit slbc_checker u_slbc_checker (.*);
